[rtl/core/iptf_pkg.sv]
// Shared types, constants and helpers for the IPv6 address text formatter.
`timescale 1ns / 1ps

package iptf_pkg;

   localparam int NumGroups         = 8;
   localparam int GroupWidth        = 16;
   localparam int CharWidth         = 7;
   localparam int ModeWidth         = 2;
   localparam int QueueDepthDefault = 2;

   localparam logic [ModeWidth-1:0] MODE_COMPRESSED = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_EXPANDED   = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_PLAIN      = 2'd2;

   localparam logic [CharWidth-1:0] CHAR_COLON    = 7'h3a;
   localparam logic [CharWidth-1:0] CHAR_DIGIT_0  = 7'h30;
   localparam logic [CharWidth-1:0] CHAR_LETTER_A = 7'h61;

   typedef logic [GroupWidth-1:0] group_type;

   // one classified request as handed from front to back
   typedef struct packed {
      group_type [NumGroups-1:0] groups;
      logic                      full;
      logic                      comp_en;
      logic [2:0]                comp_start;
      logic [3:0]                comp_end;
   } desc_type;

   function automatic logic [CharWidth-1:0] hex_char(input logic [3:0] nib);
      logic [CharWidth-1:0] res;
      if (nib < 4'd10) begin
         res = CHAR_DIGIT_0 + {3'b000, nib};
      end else begin
         res = CHAR_LETTER_A + {3'b000, nib - 4'd10};
      end
      return res;
   endfunction

   // position of the first printed nibble, 0 = most significant
   function automatic logic [1:0] first_nib(input group_type g, input logic full);
      logic [1:0] res;
      if (full || g[15:12] != 4'd0) begin
         res = 2'd0;
      end else if (g[11:8] != 4'd0) begin
         res = 2'd1;
      end else if (g[7:4] != 4'd0) begin
         res = 2'd2;
      end else begin
         res = 2'd3;
      end
      return res;
   endfunction

endpackage

[rtl/core/iptf_front.sv]
// Front end: accepts addresses and finds the zero run to compress.
`timescale 1ns / 1ps

module iptf_front (
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  iptf_pkg::group_type [iptf_pkg::NumGroups-1:0] req_groups,
   input  logic [iptf_pkg::ModeWidth-1:0]            format_mode,
   input  logic                                      q_full,
   output logic                                      q_push,
   output iptf_pkg::desc_type                        q_desc
);

   always_comb begin
      logic [3:0] run;
      logic [3:0] best;
      logic [3:0] start;
      run   = 4'd0;
      best  = 4'd0;
      start = 4'd0;
      for (int i = 0; i < iptf_pkg::NumGroups; i++) begin
         if (req_groups[i] == '0) begin
            run = run + 4'd1;
            if (run > best) begin
               best  = run;
               start = 4'(i) + 4'd1 - run;
            end
         end else begin
            run = 4'd0;
         end
      end
      q_desc.groups     = req_groups;
      q_desc.full       = (format_mode == iptf_pkg::MODE_EXPANDED);
      q_desc.comp_en    = (format_mode == iptf_pkg::MODE_COMPRESSED) && (best >= 4'd2);
      q_desc.comp_start = start[2:0];
      q_desc.comp_end   = start + best;
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

[rtl/core/iptf_queue.sv]
// Short request queue between classifier and serializer.
`timescale 1ns / 1ps

module iptf_queue #(
   parameter int Depth = iptf_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  iptf_pkg::desc_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               valid,
   output iptf_pkg::desc_type head
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr  = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt  = CntWidth'(Depth);

   iptf_pkg::desc_type    mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff,  count_in;

   assign full  = (count_ff == FullCnt);
   assign valid = (count_ff != '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/iptf_back.sv]
// Back end: serializes one address into characters, one per cycle while rsp_stall is low.
`timescale 1ns / 1ps

module iptf_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  iptf_pkg::desc_type                q_head,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [iptf_pkg::CharWidth-1:0]    rsp_text_char,
   output logic                              rsp_last_char
);

   localparam logic [1:0] ST_DIGIT = 2'd0;
   localparam logic [1:0] ST_COLON = 2'd1;
   localparam logic [1:0] ST_DBL1  = 2'd2;
   localparam logic [1:0] ST_DBL2  = 2'd3;

   iptf_pkg::desc_type             item_ff, item_in;
   logic                           active_ff, active_in;
   logic [1:0]                     st_ff, st_in;
   logic [2:0]                     grp_ff, grp_in;
   logic [1:0]                     nib_ff, nib_in;
   logic                           valid_ff, valid_in;
   logic [iptf_pkg::CharWidth-1:0] char_ff, char_in;
   logic                           last_ff, last_in;

   iptf_pkg::group_type            cur_group;
   iptf_pkg::group_type            end_group;
   logic [3:0]                     cur_nibble;
   logic [iptf_pkg::CharWidth-1:0] cur_char;
   logic                           cur_last;
   logic                           adv;
   logic                           load;
   logic [2:0]                     grp_next;

   assign cur_group = item_ff.groups[grp_ff];
   assign end_group = item_ff.groups[item_ff.comp_end[2:0]];
   assign grp_next  = grp_ff + 3'd1;
   assign adv       = active_ff && (!valid_ff || !rsp_stall);
   assign load      = q_valid && (!active_ff || (adv && cur_last));
   assign q_pop     = load;

   always_comb begin
      case (nib_ff)
         2'd0:    cur_nibble = cur_group[15:12];
         2'd1:    cur_nibble = cur_group[11:8];
         2'd2:    cur_nibble = cur_group[7:4];
         default: cur_nibble = cur_group[3:0];
      endcase
   end

   always_comb begin
      st_in    = st_ff;
      grp_in   = grp_ff;
      nib_in   = nib_ff;
      cur_char = iptf_pkg::CHAR_COLON;
      cur_last = 1'b0;
      case (st_ff)
         ST_DIGIT: begin
            cur_char = iptf_pkg::hex_char(cur_nibble);
            cur_last = (nib_ff == 2'd3) && (grp_ff == 3'd7);
            if (nib_ff != 2'd3) begin
               nib_in = nib_ff + 2'd1;
            end else if (item_ff.comp_en && grp_next == item_ff.comp_start) begin
               st_in = ST_DBL1;
            end else begin
               st_in  = ST_COLON;
               grp_in = grp_next;
            end
         end
         ST_COLON: begin
            st_in  = ST_DIGIT;
            nib_in = iptf_pkg::first_nib(cur_group, item_ff.full);
         end
         ST_DBL1: begin
            st_in = ST_DBL2;
         end
         default: begin
            cur_last = item_ff.comp_end[3];
            st_in    = ST_DIGIT;
            grp_in   = item_ff.comp_end[2:0];
            nib_in   = iptf_pkg::first_nib(end_group, item_ff.full);
         end
      endcase

      item_in   = item_ff;
      active_in = active_ff;
      if (adv && cur_last) begin
         active_in = 1'b0;
      end
      if (load) begin
         item_in   = q_head;
         active_in = 1'b1;
         grp_in    = 3'd0;
         nib_in    = iptf_pkg::first_nib(q_head.groups[0], q_head.full);
         if (q_head.comp_en && q_head.comp_start == 3'd0) begin
            st_in = ST_DBL1;
         end else begin
            st_in = ST_DIGIT;
         end
      end else if (!adv) begin
         st_in  = st_ff;
         grp_in = grp_ff;
         nib_in = nib_ff;
      end

      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (adv) begin
         valid_in = 1'b1;
         char_in  = cur_char;
         last_in  = cur_last;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         st_ff     <= ST_DIGIT;
         grp_ff    <= 3'd0;
         nib_ff    <= 2'd0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         st_ff     <= st_in;
         grp_ff    <= grp_in;
         nib_ff    <= nib_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_text_char = char_ff;
   assign rsp_last_char = last_ff;

endmodule

[rtl/core/ipv6_address_text_formatter_unit.sv]
// Top level of the IPv6 address text formatter.
`timescale 1ns / 1ps

// Takes one IPv6 address (eight 16-bit groups) per request and returns its
// text one ASCII character per response, with rsp_last_char on the final
// one. csr_format_mode selects compressed (0, longest run of two or more
// zero groups as "::"), expanded (1, four hex digits per group) or plain
// (2 and 3). An address has 2 to 39 characters, emitted by the output
// serializer one character per cycle while rsp_stall is low; a queued next
// address follows the previous last character directly. A small queue holds
// classified addresses so the request side keeps flowing while text drains.
module ipv6_address_text_formatter_unit #(
   parameter int QueueDepth = iptf_pkg::QueueDepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [iptf_pkg::ModeWidth-1:0]    csr_format_mode,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [iptf_pkg::GroupWidth-1:0]   req_group_0,
   input  logic [iptf_pkg::GroupWidth-1:0]   req_group_1,
   input  logic [iptf_pkg::GroupWidth-1:0]   req_group_2,
   input  logic [iptf_pkg::GroupWidth-1:0]   req_group_3,
   input  logic [iptf_pkg::GroupWidth-1:0]   req_group_4,
   input  logic [iptf_pkg::GroupWidth-1:0]   req_group_5,
   input  logic [iptf_pkg::GroupWidth-1:0]   req_group_6,
   input  logic [iptf_pkg::GroupWidth-1:0]   req_group_7,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [iptf_pkg::CharWidth-1:0]    rsp_text_char,
   output logic                              rsp_last_char
);

   logic [iptf_pkg::ModeWidth-1:0]               mode_ff, mode_in;
   iptf_pkg::group_type [iptf_pkg::NumGroups-1:0] groups;
   iptf_pkg::desc_type                           push_desc;
   iptf_pkg::desc_type                           head_desc;
   logic                                         q_push;
   logic                                         q_pop;
   logic                                         q_full;
   logic                                         q_valid;

   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_format_mode : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= iptf_pkg::MODE_COMPRESSED;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign groups[0] = req_group_0;
   assign groups[1] = req_group_1;
   assign groups[2] = req_group_2;
   assign groups[3] = req_group_3;
   assign groups[4] = req_group_4;
   assign groups[5] = req_group_5;
   assign groups[6] = req_group_6;
   assign groups[7] = req_group_7;

   iptf_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_groups  (groups),
      .format_mode (mode_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_desc      (push_desc)
   );

   iptf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_desc),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .head      (head_desc)
   );

   iptf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_head        (head_desc),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

[tb/sv/iptf_text_checker.sv]
// Checker for the IPv6 address text formatter: predicts the text and compares responses.
`timescale 1ns / 1ps

module iptf_text_checker
   import iptf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [ModeWidth-1:0]  csr_format_mode,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [GroupWidth-1:0] req_group_0,
   input  logic [GroupWidth-1:0] req_group_1,
   input  logic [GroupWidth-1:0] req_group_2,
   input  logic [GroupWidth-1:0] req_group_3,
   input  logic [GroupWidth-1:0] req_group_4,
   input  logic [GroupWidth-1:0] req_group_5,
   input  logic [GroupWidth-1:0] req_group_6,
   input  logic [GroupWidth-1:0] req_group_7,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [CharWidth-1:0]  rsp_text_char,
   input  logic                  rsp_last_char,
   output int                    fail_count,
   output int                    pending_chars
);

   localparam int MaxChars = 39;

   typedef logic [NumGroups-1:0][GroupWidth-1:0] address_t;

   typedef struct packed {
      logic [CharWidth-1:0] ch;
      logic                 last;
   } text_char_t;

   text_char_t           expected_text[$];
   logic [ModeWidth-1:0] active_mode = MODE_COMPRESSED;
   logic [CharWidth-1:0] text_buf [0:MaxChars-1];
   int                   text_len = 0;

   initial begin
      fail_count    = 0;
      pending_chars = 0;
   end

   task automatic report_mismatch(input string what, input logic [CharWidth-1:0] got,
                                  input logic [CharWidth-1:0] want);
      fail_count++;
      if (fail_count <= 100) begin
         $display("ERROR at %0t: %s: got %h, want %h", $time, what, got, want);
      end
   endtask

   function automatic void append_char(input logic [CharWidth-1:0] c);
      if (text_len < MaxChars) begin
         text_buf[text_len] = c;
         text_len++;
      end
   endfunction

   function automatic void append_group(input logic [GroupWidth-1:0] g, input logic full);
      logic       started;
      logic [3:0] nib;
      int         shift;
      started = full;
      for (shift = 12; shift >= 0; shift -= 4) begin
         nib = g[shift +: 4];
         if (nib != 4'd0 || shift == 0) begin
            started = 1'b1;
         end
         if (started) begin
            append_char(nib < 4'd10 ? CHAR_DIGIT_0 + {3'b000, nib}
                                    : CHAR_LETTER_A + {3'b000, nib - 4'd10});
         end
      end
   endfunction

   function automatic void append_range(input address_t a, input int from, input int upto);
      int i;
      for (i = from; i < upto; i++) begin
         if (i > from) begin
            append_char(CHAR_COLON);
         end
         append_group(a[i], 1'b0);
      end
   endfunction

   function automatic void format_address(input address_t a, input logic [ModeWidth-1:0] mode);
      int i;
      int best;
      int start;
      int run;
      text_len = 0;
      best     = 0;
      start    = 0;
      run      = 0;
      if (mode == MODE_EXPANDED) begin
         for (i = 0; i < NumGroups; i++) begin
            if (i > 0) begin
               append_char(CHAR_COLON);
            end
            append_group(a[i], 1'b1);
         end
      end else if (mode == MODE_COMPRESSED) begin
         for (i = 0; i < NumGroups; i++) begin
            if (a[i] == '0) begin
               run++;
               if (run > best) begin
                  best  = run;
                  start = i - run + 1;
               end
            end else begin
               run = 0;
            end
         end
         if (best < 2) begin
            append_range(a, 0, NumGroups);
         end else begin
            append_range(a, 0, start);
            append_char(CHAR_COLON);
            append_char(CHAR_COLON);
            append_range(a, start + best, NumGroups);
         end
      end else begin
         append_range(a, 0, NumGroups);
      end
   endfunction

   always @(posedge clock) begin
      text_char_t entry;
      address_t   addr;
      int         i;
      if (reset) begin
         expected_text.delete();
         active_mode = MODE_COMPRESSED;
         pending_chars <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               report_mismatch("character with no request pending", rsp_text_char, '0);
            end else begin
               entry = expected_text.pop_front();
               if (rsp_text_char !== entry.ch) begin
                  report_mismatch("text_char", rsp_text_char, entry.ch);
               end
               if (rsp_last_char !== entry.last) begin
                  report_mismatch("last_char", {6'd0, rsp_last_char}, {6'd0, entry.last});
               end
            end
         end
         if (csr_valid && csr_ready) begin
            active_mode = csr_format_mode;
         end
         if (req_valid && !req_stall) begin
            addr = {req_group_7, req_group_6, req_group_5, req_group_4,
                    req_group_3, req_group_2, req_group_1, req_group_0};
            format_address(addr, active_mode);
            for (i = 0; i < text_len; i++) begin
               entry.ch   = text_buf[i];
               entry.last = (i == text_len - 1);
               expected_text.push_back(entry);
            end
         end
         pending_chars <= expected_text.size();
      end
   end

endmodule

[tb/sv/tb_top.sv]
// Top of the IPv6 address text formatter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import iptf_pkg::*;

   localparam logic [ModeWidth-1:0] MODE_UNUSED = 2'd3;
   localparam int CycleLimit = 500000;

   typedef logic [NumGroups-1:0][GroupWidth-1:0] address_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [ModeWidth-1:0]  csr_format_mode = MODE_COMPRESSED;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [GroupWidth-1:0] req_group_0 = '0;
   logic [GroupWidth-1:0] req_group_1 = '0;
   logic [GroupWidth-1:0] req_group_2 = '0;
   logic [GroupWidth-1:0] req_group_3 = '0;
   logic [GroupWidth-1:0] req_group_4 = '0;
   logic [GroupWidth-1:0] req_group_5 = '0;
   logic [GroupWidth-1:0] req_group_6 = '0;
   logic [GroupWidth-1:0] req_group_7 = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CharWidth-1:0]  rsp_text_char;
   logic                  rsp_last_char;

   int   fail_count;
   int   pending_chars;
   int   cycle_count = 0;
   int   rsp_hold = 0;
   logic quiet = 1'b0;

   ipv6_address_text_formatter_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_format_mode (csr_format_mode),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_group_0     (req_group_0),
      .req_group_1     (req_group_1),
      .req_group_2     (req_group_2),
      .req_group_3     (req_group_3),
      .req_group_4     (req_group_4),
      .req_group_5     (req_group_5),
      .req_group_6     (req_group_6),
      .req_group_7     (req_group_7),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char)
   );

   iptf_text_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_format_mode (csr_format_mode),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_group_0     (req_group_0),
      .req_group_1     (req_group_1),
      .req_group_2     (req_group_2),
      .req_group_3     (req_group_3),
      .req_group_4     (req_group_4),
      .req_group_5     (req_group_5),
      .req_group_6     (req_group_6),
      .req_group_7     (req_group_7),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char),
      .fail_count      (fail_count),
      .pending_chars   (pending_chars)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // response-side stall bursts
   always @(posedge clock) begin
      if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_hold == 1) begin
         rsp_hold  <= 0;
         rsp_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  <= $urandom_range(1, 5);
      end
   end

   function automatic address_t pack_groups(input logic [15:0] g0, g1, g2, g3,
                                            input logic [15:0] g4, g5, g6, g7);
      return {g7, g6, g5, g4, g3, g2, g1, g0};
   endfunction

   function automatic address_t random_address();
      address_t a;
      int       i;
      int       len;
      int       start;
      for (i = 0; i < NumGroups; i++) begin
         case ($urandom_range(0, 3))
            0:       a[i] = '0;
            1:       a[i] = 16'($urandom_range(0, 15)) << (4 * $urandom_range(0, 3));
            default: a[i] = 16'($urandom);
         endcase
      end
      if ($urandom_range(0, 9) < 6) begin
         len   = $urandom_range(1, NumGroups);
         start = $urandom_range(0, NumGroups - len);
         for (i = start; i < start + len; i++) begin
            a[i] = '0;
         end
      end
      return a;
   endfunction

   task automatic send_address(input address_t a);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_group_0 <= a[0];
      req_group_1 <= a[1];
      req_group_2 <= a[2];
      req_group_3 <= a[3];
      req_group_4 <= a[4];
      req_group_5 <= a[5];
      req_group_6 <= a[6];
      req_group_7 <= a[7];
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_address(random_address());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_chars != 0) @(posedge clock);
   endtask

   task automatic write_mode(input logic [ModeWidth-1:0] mode);
      wait_drained();
      csr_valid       <= 1'b1;
      csr_format_mode <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_mode(MODE_COMPRESSED);
      send_address(pack_groups(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
      send_address(pack_groups(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1));
      send_address(pack_groups(16'h1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
      send_address(pack_groups(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                               16'hffff, 16'hffff, 16'hffff, 16'hffff));
      send_address(pack_groups(16'h1, 16'h0, 16'h2, 16'h3, 16'h4, 16'h5, 16'h6, 16'h7));
      send_address(pack_groups(16'h1, 16'h0, 16'h0, 16'h2, 16'h0, 16'h0, 16'h3, 16'h4));
      send_address(pack_groups(16'h1, 16'h0, 16'h0, 16'h2, 16'h0, 16'h0, 16'h0, 16'h3));
      send_address(pack_groups(16'h0, 16'h0, 16'h1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h2));
      send_address(pack_groups(16'h1000, 16'h0100, 16'h0010, 16'h0001,
                               16'habcd, 16'h0f0f, 16'hf000, 16'h000a));
      send_address(pack_groups(16'h0, 16'h1, 16'h0, 16'h1, 16'h0, 16'h1, 16'h0, 16'h1));
      send_address(pack_groups(16'h2001, 16'h0db8, 16'h0, 16'h0,
                               16'h0, 16'hff00, 16'h0042, 16'h8329));
      send_random(60);
      wait_drained();
      send_random(40);

      write_mode(MODE_EXPANDED);
      quiet = 1'b1;
      send_address(pack_groups(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
      send_address(pack_groups(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                               16'hffff, 16'hffff, 16'hffff, 16'hffff));
      send_address(pack_groups(16'h1000, 16'h0100, 16'h0010, 16'h0001,
                               16'habcd, 16'h0f0f, 16'hf000, 16'h000a));
      send_random(10);
      quiet = 1'b0;
      send_random(40);

      write_mode(MODE_PLAIN);
      send_address(pack_groups(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
      send_address(pack_groups(16'h1, 16'h0, 16'h0, 16'h2, 16'h0, 16'h0, 16'h3, 16'h4));
      send_address(pack_groups(16'h1000, 16'h0100, 16'h0010, 16'h0001,
                               16'habcd, 16'h0f0f, 16'hf000, 16'h000a));
      send_random(50);

      write_mode(MODE_UNUSED);
      send_address(pack_groups(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
      send_address(pack_groups(16'h1, 16'h0, 16'h0, 16'h2, 16'h0, 16'h0, 16'h0, 16'h3));
      send_random(30);

      write_mode(MODE_COMPRESSED);
      send_random(40);
      quiet = 1'b1;
      send_random(40);

      wait_drained();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_chars == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/iptf_pkg.sv
rtl/core/iptf_front.sv
rtl/core/iptf_queue.sv
rtl/core/iptf_back.sv
rtl/core/ipv6_address_text_formatter_unit.sv
tb/sv/iptf_text_checker.sv
tb/sv/tb_top.sv
